[sv/iir_df1_pkg.sv]
// Shared types and constants for the direct form I IIR filter.
`default_nettype none
package iir_df1_pkg;

   localparam int SAMPLE_BITS            = 24;
   localparam int COEF_BITS              = 24;
   localparam int REG_TAPS               = 4;
   localparam int TAPS_BITS              = 3;
   localparam int CSR_INDEX_BITS         = 3;
   localparam int MAX_TAPS_DEFAULT       = 4;
   localparam int COEF_FRAC_BITS_DEFAULT = 20;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TAPS_IN_USE,
      CSR_FEED_TAP0,
      CSR_FEED_TAP1,
      CSR_FEED_TAP2,
      CSR_FEED_TAP3,
      CSR_BACK_TAP1,
      CSR_BACK_TAP2,
      CSR_BACK_TAP3
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          restart;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          clipped;
   } rsp_payload_type;

   typedef struct packed {
      logic [TAPS_BITS-1:0]                      taps_in_use;
      logic [REG_TAPS-1:0][COEF_BITS-1:0]        feed_tap;
      logic [REG_TAPS-1:1][COEF_BITS-1:0]        back_tap;
   } cfg_type;

endpackage
`default_nettype wire

[sv/iir_df1_cfg.sv]
// Configuration register file: tap count and feed/feedback coefficients.
`default_nettype none
module iir_df1_cfg #(
   parameter int COEF_FRAC_BITS = iir_df1_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_valid,
   input  wire logic [iir_df1_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [iir_df1_pkg::COEF_BITS-1:0]       csr_data,
   output iir_df1_pkg::cfg_type                         cfg
);

   localparam logic [iir_df1_pkg::COEF_BITS-1:0] UNITY =
      iir_df1_pkg::COEF_BITS'(1) << COEF_FRAC_BITS;
   localparam iir_df1_pkg::cfg_type CFG_RESET = {
      iir_df1_pkg::TAPS_BITS'(1),
      (iir_df1_pkg::REG_TAPS * iir_df1_pkg::COEF_BITS)'(UNITY),
      {((iir_df1_pkg::REG_TAPS - 1) * iir_df1_pkg::COEF_BITS){1'b0}}
   };

   iir_df1_pkg::cfg_type cfg_ff;
   iir_df1_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (iir_df1_pkg::csr_index_type'(csr_index))
            iir_df1_pkg::CSR_TAPS_IN_USE:
               cfg_in.taps_in_use = csr_data[iir_df1_pkg::TAPS_BITS-1:0];
            iir_df1_pkg::CSR_FEED_TAP0: cfg_in.feed_tap[0] = csr_data;
            iir_df1_pkg::CSR_FEED_TAP1: cfg_in.feed_tap[1] = csr_data;
            iir_df1_pkg::CSR_FEED_TAP2: cfg_in.feed_tap[2] = csr_data;
            iir_df1_pkg::CSR_FEED_TAP3: cfg_in.feed_tap[3] = csr_data;
            iir_df1_pkg::CSR_BACK_TAP1: cfg_in.back_tap[1] = csr_data;
            iir_df1_pkg::CSR_BACK_TAP2: cfg_in.back_tap[2] = csr_data;
            iir_df1_pkg::CSR_BACK_TAP3: cfg_in.back_tap[3] = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[sv/iir_df1_calc.sv]
// Single-pass datapath: parallel tap products, sum, rounding and saturation.
`default_nettype none
module iir_df1_calc #(
   parameter int MAX_TAPS       = iir_df1_pkg::MAX_TAPS_DEFAULT,
   parameter int COEF_FRAC_BITS = iir_df1_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  wire iir_df1_pkg::cfg_type                                  cfg,
   input  wire logic [iir_df1_pkg::SAMPLE_BITS-1:0]                   sample,
   input  wire logic [MAX_TAPS-2:0][iir_df1_pkg::SAMPLE_BITS-1:0]     hist_x,
   input  wire logic [MAX_TAPS-2:0][iir_df1_pkg::SAMPLE_BITS-1:0]     hist_y,
   output logic [iir_df1_pkg::SAMPLE_BITS-1:0]                        result,
   output logic                                                       clip
);

   localparam int SB        = iir_df1_pkg::SAMPLE_BITS;
   localparam int PROD_BITS = SB + iir_df1_pkg::COEF_BITS;
   localparam int ACC_BITS  = PROD_BITS + 3;
   localparam logic signed [ACC_BITS-1:0] HALF =
      ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_BITS-1:0] SAT_HI =
      {{(ACC_BITS-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] SAT_LO =
      {{(ACC_BITS-SB+1){1'b1}}, {(SB-1){1'b0}}};

   logic [iir_df1_pkg::TAPS_BITS-1:0] n_taps;
   logic signed [PROD_BITS-1:0]       prod_ff_x [MAX_TAPS];
   logic signed [PROD_BITS-1:0]       prod_fb [1:MAX_TAPS-1];
   logic signed [ACC_BITS-1:0]        acc;
   logic signed [ACC_BITS-1:0]        q_full;

   always_comb begin
      if (cfg.taps_in_use == '0) begin
         n_taps = iir_df1_pkg::TAPS_BITS'(1);
      end else if (cfg.taps_in_use > iir_df1_pkg::TAPS_BITS'(MAX_TAPS)) begin
         n_taps = iir_df1_pkg::TAPS_BITS'(MAX_TAPS);
      end else begin
         n_taps = cfg.taps_in_use;
      end
   end

   always_comb begin
      prod_ff_x[0] = PROD_BITS'($signed(sample)) * PROD_BITS'($signed(cfg.feed_tap[0]));
      for (int k = 1; k < MAX_TAPS; k++) begin
         prod_ff_x[k] = PROD_BITS'($signed(hist_x[k-1]))
                        * PROD_BITS'($signed(cfg.feed_tap[k]));
         prod_fb[k]   = PROD_BITS'($signed(hist_y[k-1]))
                        * PROD_BITS'($signed(cfg.back_tap[k]));
      end
   end

   always_comb begin
      acc = ACC_BITS'(prod_ff_x[0]);
      for (int k = 1; k < MAX_TAPS; k++) begin
         if (iir_df1_pkg::TAPS_BITS'(k) < n_taps) begin
            acc = acc + ACC_BITS'(prod_ff_x[k]) - ACC_BITS'(prod_fb[k]);
         end
      end
      q_full = (acc + HALF) >>> COEF_FRAC_BITS;
      if (q_full > SAT_HI) begin
         result = SAT_HI[SB-1:0];
         clip   = 1'b1;
      end else if (q_full < SAT_LO) begin
         result = SAT_LO[SB-1:0];
         clip   = 1'b1;
      end else begin
         result = q_full[SB-1:0];
         clip   = 1'b0;
      end
   end

endmodule
`default_nettype wire

[sv/iir_filter_direct_form_one.sv]
// Top level of the streaming direct form I IIR filter.
//
// Samples enter on the req_ channel and filtered samples leave on the rsp_
// channel, both valid/ready; a transfer happens when valid and ready are high.
// An accepted sample is held in an input register, where all tap products,
// the sum, rounding and saturation are formed in one pass; the result is
// then written to the output register and the histories advance.
// rsp_valid rises when the sample reaches the output register; throughput is
// one sample per cycle when not stalled, set by the one-pass output feedback.
// If the receiver stalls, the output register holds its result and the input
// register holds one more sample; req_ready drops only when both are full.
// Setting restart with a sample zeroes both histories before that sample.
// Coefficients are written on the csr_ channel, which is always ready; write
// them only while no sample is in flight.
// Synchronous reset empties the pipeline, zeroes the histories and restores
// the default registers: one tap, feed tap 0 at unity gain.
`default_nettype none
module iir_filter_direct_form_one #(
   parameter int MAX_TAPS       = iir_df1_pkg::MAX_TAPS_DEFAULT,
   parameter int COEF_FRAC_BITS = iir_df1_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire iir_df1_pkg::req_payload_type            req_data,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output iir_df1_pkg::rsp_payload_type                 rsp_data,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [iir_df1_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [iir_df1_pkg::COEF_BITS-1:0]       csr_data
);

   localparam int SB = iir_df1_pkg::SAMPLE_BITS;
   localparam int HD = MAX_TAPS - 1;

   iir_df1_pkg::cfg_type          cfg;
   iir_df1_pkg::req_payload_type  s1_data_ff;
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   iir_df1_pkg::rsp_payload_type  out_data_ff;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic [HD-1:0][SB-1:0]         past_x_ff;
   logic [HD-1:0][SB-1:0]         past_y_ff;
   logic [HD-1:0][SB-1:0]         hist_x;
   logic [HD-1:0][SB-1:0]         hist_y;
   logic [SB-1:0]                 result;
   logic                          clip;
   logic                          advance;
   logic                          req_xfer;

   assign csr_ready = 1'b1;

   iir_df1_cfg #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign hist_x = s1_data_ff.restart ? '0 : past_x_ff;
   assign hist_y = s1_data_ff.restart ? '0 : past_y_ff;

   iir_df1_calc #(
      .MAX_TAPS       (MAX_TAPS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_calc (
      .cfg    (cfg),
      .sample (s1_data_ff.sample_in),
      .hist_x (hist_x),
      .hist_y (hist_y),
      .result (result),
      .clip   (clip)
   );

   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         s1_valid_in  = 1'b0;
      end
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff.sample_out <= result;
         out_data_ff.clipped    <= clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         past_x_ff <= '0;
         past_y_ff <= '0;
      end else if (advance) begin
         past_x_ff[0] <= s1_data_ff.sample_in;
         past_y_ff[0] <= result;
         for (int k = 1; k < HD; k++) begin
            past_x_ff[k] <= hist_x[k-1];
            past_y_ff[k] <= hist_y[k-1];
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_feedback_matches_output : assert property (
      @(posedge clock) disable iff (reset)
      advance |=> (past_y_ff[0] == out_data_ff.sample_out)
                  && (past_x_ff[0] == $past(s1_data_ff.sample_in)))
      else $error("history update does not match delivered result");

   a_clip_at_limit : assert property (
      @(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.clipped) |->
         (out_data_ff.sample_out == {1'b0, {(SB-1){1'b1}}})
         || (out_data_ff.sample_out == {1'b1, {(SB-1){1'b0}}}))
      else $error("clipped result is not at a saturation limit");

   a_input_stage_holds : assert property (
      @(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("stalled input stage lost or changed its sample");

   a_no_overwrite : assert property (
      @(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !advance)
      else $error("output register overwritten while stalled");

endmodule
`default_nettype wire
